// ===== design/askg_pkg.sv =====
// Shared types, widths and constants for the angular-spectrum kernel generator.
// Used by every module of the block; depends on nothing.
package askg_pkg;

  localparam int unsigned MAX_DIM = 4096;

  localparam int IDX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int CIDX_W = 14;
  localparam int SQ_W   = 27;
  localparam int STEP_W = 32;
  localparam int TZ_W   = 48;
  localparam int RAD_W  = 33;
  localparam int ROOT_W = 25;
  localparam int PH_W   = 32;
  localparam int ANG_W  = 30;
  localparam int MAG_W  = 16;
  localparam int DIV_W  = 6;
  localparam int RCP_W  = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam int HSTEPS   = 3;
  localparam int LANE_LAT = 3 * HSTEPS + 2;

  localparam logic [ANG_W:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [ANG_W-1:0] EIGHTH    = 30'h2000_0000;
  localparam logic [31:0]    TWO_PI_FRAC = 32'd2451551556;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COLS,
    REG_ROWS,
    REG_FX,
    REG_FY,
    REG_TZ
  } cfg_reg_t;

  typedef enum logic {
    LANE_SIN,
    LANE_COS
  } lane_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic  valid;
    logic  evan;
    quad_t quad;
    logic  swap;
  } side_t;

  function automatic logic [DIV_W-1:0] horner_div(lane_t kind, logic [1:0] j);
    logic [DIV_W-1:0] d;
    d = 6'd1;
    case ({kind, j})
      {LANE_SIN, 2'd0}: d = 6'd42;
      {LANE_SIN, 2'd1}: d = 6'd20;
      {LANE_SIN, 2'd2}: d = 6'd6;
      {LANE_COS, 2'd0}: d = 6'd56;
      {LANE_COS, 2'd1}: d = 6'd30;
      {LANE_COS, 2'd2}: d = 6'd12;
      default:          d = 6'd1;
    endcase
    return d;
  endfunction

  // Reciprocals are floor(2^32 / d); the quotient estimate is low by at most one.
  function automatic logic [RCP_W-1:0] horner_recip(lane_t kind, logic [1:0] j);
    logic [RCP_W-1:0] m;
    m = 32'hFFFF_FFFF;
    case ({kind, j})
      {LANE_SIN, 2'd0}: m = 32'd102261126;
      {LANE_SIN, 2'd1}: m = 32'd214748364;
      {LANE_SIN, 2'd2}: m = 32'd715827882;
      {LANE_COS, 2'd0}: m = 32'd76695844;
      {LANE_COS, 2'd1}: m = 32'd143165576;
      {LANE_COS, 2'd2}: m = 32'd357913941;
      default:          m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== design/angular_spectrum_kernel_gen.sv =====
// Top level of the angular-spectrum kernel generator: configuration registers,
// pipeline, quadrant rotation and output register. Depends on askg_pkg and all askg_ modules.
//
// Channel  Direction  Beat contents
// in_      slave      tdata = row[11:0], col[23:12]
// out_     master     tdata = re[15:0], im[31:16]; tuser = evanescent
// cfg_     slave      addr = register index, data = register value
//
// One coordinate enters per cycle unless the output stalls; it passes the radicand, the
// 25 square-root stages, the phase and the three Horner steps of the sine and cosine lanes.
// Reset clears every valid bit and loads the register reset values; no clearing pass.
// While out_tvalid is high and out_tready is low the whole pipeline holds in place.
module angular_spectrum_kernel_gen import askg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // row[11:0], col[23:12]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // re[15:0], im[31:16]
  output logic                  out_tuser,  // evanescent[0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0]  cols_r, rows_r;
  logic [STEP_W-1:0] fx_r, fy_r;
  logic [TZ_W-1:0]   tz_r;
  logic              en;

  side_t             rad_side, sq_side, ph_side;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [ANG_W-1:0]  th, x2;
  logic [MAG_W-1:0]  sin_mag, cos_mag;
  side_t             dly_r [LANE_LAT];
  side_t             last;
  logic signed [MAG_W-1:0] s0, c0, re, im;

  logic              out_valid_r, out_evan_r;
  logic [MAG_W-1:0]  out_re_r, out_im_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 13'd256;
      rows_r <= 13'd256;
      fx_r   <= '0;
      fy_r   <= '0;
      tz_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_COLS: cols_r <= cfg_data[DIM_W-1:0];
        REG_ROWS: rows_r <= cfg_data[DIM_W-1:0];
        REG_FX:   fx_r   <= cfg_data[STEP_W-1:0];
        REG_FY:   fy_r   <= cfg_data[STEP_W-1:0];
        REG_TZ:   tz_r   <= cfg_data[TZ_W-1:0];
        default: ;
      endcase
    end
  end

  askg_radicand u_rad (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .row        (in_tdata[11:0]),
    .col        (in_tdata[23:12]),
    .cols       (cols_r),
    .rows       (rows_r),
    .fx_step_sq (fx_r),
    .fy_step_sq (fy_r),
    .side       (rad_side),
    .rad        (rad)
  );

  askg_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_side (rad_side),
    .rad     (rad),
    .side    (sq_side),
    .root    (root)
  );

  askg_phase u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_side     (sq_side),
    .root        (root),
    .turns_per_z (tz_r),
    .side        (ph_side),
    .th          (th),
    .x2          (x2)
  );

  askg_lane u_sin (
    .clk  (clk),
    .en   (en),
    .kind (LANE_SIN),
    .th   (th),
    .x2   (x2),
    .mag  (sin_mag)
  );

  askg_lane u_cos (
    .clk  (clk),
    .en   (en),
    .kind (LANE_COS),
    .th   (th),
    .x2   (x2),
    .mag  (cos_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        dly_r[i] <= '0;
      end
    end else if (en) begin
      dly_r[0] <= ph_side;
      for (int i = 1; i < LANE_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign last = dly_r[LANE_LAT-1];

  always_comb begin
    s0 = last.swap ? $signed(cos_mag) : $signed(sin_mag);
    c0 = last.swap ? $signed(sin_mag) : $signed(cos_mag);
    re = c0;
    im = s0;
    case (last.quad)
      QUAD_0: begin
        re = c0;
        im = s0;
      end
      QUAD_1: begin
        re = -s0;
        im = c0;
      end
      QUAD_2: begin
        re = -c0;
        im = -s0;
      end
      QUAD_3: begin
        re = s0;
        im = -c0;
      end
      default: begin
        re = c0;
        im = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_evan_r <= last.evan;
      out_re_r   <= last.evan ? '0 : re;
      out_im_r   <= last.evan ? '0 : im;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_im_r, out_re_r};
  assign out_tuser  = out_evan_r;

`ifndef NO_ASSERTIONS
  a_evan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'b0)
    else $error("evanescent beat carries nonzero re or im");

  a_unit_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata != 32'b0)
    else $error("propagating beat has zero magnitude");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dly_r[LANE_LAT-1]))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== design/askg_radicand.sv =====
// Centering of the coordinate and the radicand 1 - fx*jc^2 - fy*ic^2 in Q.32.
// Four register stages; depends on askg_pkg.
module askg_radicand import askg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [IDX_W-1:0]        row,
  input  logic [IDX_W-1:0]        col,
  input  logic [DIM_W-1:0]        cols,
  input  logic [DIM_W-1:0]        rows,
  input  logic [STEP_W-1:0]       fx_step_sq,
  input  logic [STEP_W-1:0]       fy_step_sq,
  output side_t                   side,
  output logic [RAD_W-1:0]        rad
);

  function automatic logic signed [CIDX_W-1:0] center(logic [IDX_W-1:0] idx,
                                                       logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] d;
    logic [DIM_W-1:0] h;
    d = ({4'b0, dim} > 17'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim;
    h = d >> 1;
    if ({1'b0, idx} < h) begin
      return $signed({2'b0, idx});
    end
    return $signed({2'b0, idx}) - $signed({1'b0, d});
  endfunction

  logic                     v1_r, v2_r, v3_r;
  logic signed [CIDX_W-1:0] ic_r, jc_r;
  logic [SQ_W-1:0]          iq_r, jq_r;
  logic [STEP_W+SQ_W-1:0]   mx_r, my_r;
  logic [STEP_W+SQ_W:0]     sum;
  logic signed [2*CIDX_W-1:0] isq, jsq;
  side_t                    side_r;
  logic [RAD_W-1:0]         rad_r;

  assign isq = ic_r * ic_r;
  assign jsq = jc_r * jc_r;
  assign sum = {1'b0, mx_r} + {1'b0, my_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      side_r <= '0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      side_r.valid <= v3_r;
      side_r.evan  <= sum > 60'h1_0000_0000;
      side_r.quad  <= QUAD_0;
      side_r.swap  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ic_r  <= center(row, rows);
      jc_r  <= center(col, cols);
      iq_r  <= isq[SQ_W-1:0];
      jq_r  <= jsq[SQ_W-1:0];
      mx_r  <= (STEP_W+SQ_W)'(fx_step_sq) * (STEP_W+SQ_W)'(jq_r);
      my_r  <= (STEP_W+SQ_W)'(fy_step_sq) * (STEP_W+SQ_W)'(iq_r);
      rad_r <= 33'h1_0000_0000 - sum[RAD_W-1:0];
    end
  end

  assign side = side_r;
  assign rad  = rad_r;

endmodule

// ===== design/askg_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Computes floor(sqrt(rad * 2^16)); depends on askg_pkg.
module askg_sqrt import askg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  side_t             in_side,
  input  logic [RAD_W-1:0]  rad,
  output side_t             side,
  output logic [ROOT_W-1:0] root
);

  localparam int STEPS = ROOT_W;
  localparam int REM_W = 50;

  logic [REM_W-1:0]  rem_w [STEPS];
  logic [ROOT_W-1:0] res_w [STEPS];
  side_t             sd_w  [STEPS];
  logic [REM_W-1:0]  rem_r [STEPS];
  logic [ROOT_W-1:0] res_r [STEPS];
  side_t             sd_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = STEPS - 1 - k;
    logic [REM_W-1:0] delta;

    if (k == 0) begin : g_first
      assign rem_w[k] = {1'b0, rad, 16'b0};
      assign res_w[k] = '0;
      assign sd_w[k]  = in_side;
    end else begin : g_next
      assign rem_w[k] = rem_r[k-1];
      assign res_w[k] = res_r[k-1];
      assign sd_w[k]  = sd_r[k-1];
    end

    assign delta = (REM_W'(res_w[k]) << (SH + 1)) | (REM_W'(1) << (2 * SH));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[k] <= '0;
      end else if (en) begin
        sd_r[k] <= sd_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_w[k] >= delta) begin
          rem_r[k] <= rem_w[k] - delta;
          res_r[k] <= res_w[k] | (ROOT_W'(1) << SH);
        end else begin
          rem_r[k] <= rem_w[k];
          res_r[k] <= res_w[k];
        end
      end
    end
  end

  assign side = sd_r[STEPS-1];
  assign root = res_r[STEPS-1];

endmodule

// ===== design/askg_phase.sv =====
// Phase in turns, octant folding, angle in radians and its square.
// Six register stages; depends on askg_pkg.
module askg_phase import askg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  side_t             in_side,
  input  logic [ROOT_W-1:0] root,
  input  logic [TZ_W-1:0]   turns_per_z,
  output side_t             side,
  output logic [ANG_W-1:0]  th,
  output logic [ANG_W-1:0]  x2
);

  side_t                    sd_r [6];
  logic [56:0]              plo_r;
  logic [15:0]              phi_r;
  logic [40:0]              phi_full;
  logic [TZ_W-1:0]          p48;
  logic [PH_W-1:0]          p_r;
  logic [ANG_W-1:0]         f;
  logic                     fold;
  logic [ANG_W-1:0]         g_r, g2_r;
  logic [61:0]              gm_r;
  logic [ANG_W-1:0]         th_r, th2_r, x2_r;
  logic [2*ANG_W-1:0]       thsq;

  assign phi_full = 41'(turns_per_z[47:32]) * 41'(root);
  assign p48      = plo_r[47:0] + {phi_r, 32'b0};
  assign f        = p_r[ANG_W-1:0];
  assign fold     = f > EIGHTH;
  assign thsq     = th_r * th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        sd_r[i] <= '0;
      end
    end else if (en) begin
      sd_r[0] <= in_side;
      sd_r[1] <= sd_r[0];
      sd_r[2].valid <= sd_r[1].valid;
      sd_r[2].evan  <= sd_r[1].evan;
      sd_r[2].quad  <= quad_t'(p_r[31:30]);
      sd_r[2].swap  <= fold;
      sd_r[3] <= sd_r[2];
      sd_r[4] <= sd_r[3];
      sd_r[5] <= sd_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= 57'(turns_per_z[31:0]) * 57'(root);
      phi_r <= phi_full[15:0];
      p_r   <= p48[47:16];
      g_r   <= fold ? ANG_W'(Q30_ONE - {1'b0, f}) : f;
      gm_r  <= 62'(g_r) * 62'(TWO_PI_FRAC);
      g2_r  <= g_r;
      th_r  <= g2_r + gm_r[61:32];
      th2_r <= th_r;
      x2_r  <= thsq[2*ANG_W-1:ANG_W];
    end
  end

  assign side = sd_r[5];
  assign th   = th2_r;
  assign x2   = x2_r;

endmodule

// ===== design/askg_lane.sv =====
// One Horner polynomial lane for sine or cosine of a folded angle, output in Q1.15.
// Eleven register stages; depends on askg_pkg.
module askg_lane import askg_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  lane_t            kind,
  input  logic [ANG_W-1:0] th,
  input  logic [ANG_W-1:0] x2,
  output logic [MAG_W-1:0] mag
);

  logic [ANG_W-1:0] y_w   [HSTEPS];
  logic [ANG_W-1:0] x2_w  [HSTEPS];
  logic [ANG_W-1:0] th_w  [HSTEPS];
  logic [ANG_W-1:0] qe_r  [HSTEPS];
  logic [ANG_W-1:0] ya_r  [HSTEPS];
  logic [ANG_W-1:0] x2a_r [HSTEPS];
  logic [ANG_W-1:0] tha_r [HSTEPS];
  logic [ANG_W:0]   t_r   [HSTEPS];
  logic [ANG_W-1:0] x2b_r [HSTEPS];
  logic [ANG_W-1:0] thb_r [HSTEPS];
  logic [ANG_W-1:0] yc_r  [HSTEPS];
  logic [ANG_W-1:0] x2c_r [HSTEPS];
  logic [ANG_W-1:0] thc_r [HSTEPS];
  logic [ANG_W:0]   v_r;
  logic [ANG_W:0]   rnd;
  logic [MAG_W-1:0] mag_r;

  for (genvar j = 0; j < HSTEPS; j++) begin : g_hstep
    logic [ANG_W+RCP_W-1:0] est;
    logic [ANG_W+DIV_W-1:0] back;
    logic [ANG_W-1:0]       rem;
    logic [ANG_W-1:0]       quo;
    logic [ANG_W-1:0]       mul_src;
    logic [2*ANG_W:0]       prod;
    logic [DIV_W-1:0]       d;

    if (j == 0) begin : g_first
      assign y_w[j]  = x2;
      assign x2_w[j] = x2;
      assign th_w[j] = th;
    end else begin : g_next
      assign y_w[j]  = yc_r[j-1];
      assign x2_w[j] = x2c_r[j-1];
      assign th_w[j] = thc_r[j-1];
    end

    assign d       = horner_div(kind, 2'(j));
    assign est     = (ANG_W+RCP_W)'(y_w[j]) * (ANG_W+RCP_W)'(horner_recip(kind, 2'(j)));
    assign back    = (ANG_W+DIV_W)'(qe_r[j]) * (ANG_W+DIV_W)'(d);
    assign rem     = ya_r[j] - back[ANG_W-1:0];
    assign quo     = (rem >= ANG_W'(d)) ? qe_r[j] + 1'b1 : qe_r[j];
    assign mul_src = (j == HSTEPS - 1 && kind == LANE_SIN) ? thb_r[j] : x2b_r[j];
    assign prod    = (2*ANG_W+1)'(mul_src) * (2*ANG_W+1)'(t_r[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        qe_r[j]  <= est[ANG_W+RCP_W-1:RCP_W];
        ya_r[j]  <= y_w[j];
        x2a_r[j] <= x2_w[j];
        tha_r[j] <= th_w[j];
        t_r[j]   <= Q30_ONE - {1'b0, quo};
        x2b_r[j] <= x2a_r[j];
        thb_r[j] <= tha_r[j];
        yc_r[j]  <= prod[2*ANG_W-1:ANG_W];
        x2c_r[j] <= x2b_r[j];
        thc_r[j] <= thb_r[j];
      end
    end
  end

  assign rnd = v_r + 31'h4000;

  always_ff @(posedge clk) begin
    if (en) begin
      if (kind == LANE_SIN) begin
        v_r <= {1'b0, yc_r[HSTEPS-1]};
      end else begin
        v_r <= Q30_ONE - {2'b0, yc_r[HSTEPS-1][ANG_W-1:1]};
      end
      mag_r <= rnd[ANG_W] ? 16'h7FFF : {1'b0, rnd[ANG_W-1:15]};
    end
  end

  assign mag = mag_r;

endmodule
